[rtl/smbq_pkg.sv]
// Shared types and constants for the sorted multiset bound query unit.
// Holds request/response payload structs, the request kind codes and the
// token that travels along the cell chain. No dependencies.
package smbq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic signed [31:0] MISSING_RESET = -32'sd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key_value;
        logic signed [31:0] upper_key;
        logic [5:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [31:0] at_least;
        logic signed [31:0] above;
        logic signed [31:0] at_most;
        logic signed [31:0] below;
        logic [6:0]         less_count;
        logic [6:0]         less_equal_count;
        logic [6:0]         equal_count;
        logic [6:0]         range_count;
        logic               present;
        logic signed [31:0] ranked_element;
        logic [6:0]         size;
        logic               dropped;
    } rsp_t;

    typedef struct packed {
        logic               insert;
        logic               dropped;
        logic signed [31:0] key;
        logic signed [31:0] upk;
        logic [5:0]         pos;
        logic signed [31:0] carry;
        logic               ge_found;
        logic signed [31:0] ge_val;
        logic               gt_found;
        logic signed [31:0] gt_val;
        logic signed [31:0] le_val;
        logic signed [31:0] lt_val;
        logic               rank_found;
        logic signed [31:0] rank_val;
    } tok_t;

endpackage

[rtl/smbq_cell.sv]
// One cell of the sorted chain: holds one element, applies the passing
// token's insertion and folds its element into the token's query results.
// Depends on smbq_pkg.
module smbq_cell #(
    parameter int DEPTH = smbq_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          valid_in,
    input  smbq_pkg::tok_t tok_in,
    input  logic [CW-1:0] n_in,
    input  logic [CW-1:0] lo_in,
    input  logic [CW-1:0] le_in,
    input  logic [CW-1:0] rc_in,
    output logic          valid_out,
    output smbq_pkg::tok_t tok_out,
    output logic [CW-1:0] n_out,
    output logic [CW-1:0] lo_out,
    output logic [CW-1:0] le_out,
    output logic [CW-1:0] rc_out
);
    import smbq_pkg::*;

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic signed [31:0] stored_reg;
    logic signed [31:0] stored_next;
    logic               valid_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      le_reg;
    logic [CW-1:0]      rc_reg;
    logic [CW-1:0]      lo_next;
    logic [CW-1:0]      le_next;
    logic [CW-1:0]      rc_next;

    logic occupied;
    logic lt_k;
    logic le_k;
    logic lt_u;

    always_comb
    begin
        tok_next    = tok_in;
        stored_next = stored_reg;
        if (tok_in.insert && (IDX_P1 == n_in))
        begin
            stored_next = tok_in.carry;
        end
        else if (tok_in.insert && (IDX_P1 < n_in) && (stored_reg > tok_in.carry))
        begin
            stored_next   = tok_in.carry;
            tok_next.carry = stored_reg;
        end

        occupied = IDX_C < n_in;
        lt_k = occupied && (stored_next < tok_in.key);
        le_k = occupied && (stored_next <= tok_in.key);
        lt_u = occupied && (stored_next < tok_in.upk);

        lo_next = lo_in + CW'(lt_k);
        le_next = le_in + CW'(le_k);
        rc_next = rc_in + CW'(lt_u);

        if (occupied && !tok_in.ge_found && !lt_k)
        begin
            tok_next.ge_found = 1'b1;
            tok_next.ge_val   = stored_next;
        end
        if (occupied && !tok_in.gt_found && !le_k)
        begin
            tok_next.gt_found = 1'b1;
            tok_next.gt_val   = stored_next;
        end
        if (le_k)
        begin
            tok_next.le_val = stored_next;
        end
        if (lt_k)
        begin
            tok_next.lt_val = stored_next;
        end
        if (occupied && (32'(tok_in.pos) == 32'(IDX)))
        begin
            tok_next.rank_found = 1'b1;
            tok_next.rank_val   = stored_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            stored_reg <= stored_next;
            tok_reg    <= tok_next;
            n_reg      <= n_in;
            lo_reg     <= lo_next;
            le_reg     <= le_next;
            rc_reg     <= rc_next;
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;
    assign n_out     = n_reg;
    assign lo_out    = lo_reg;
    assign le_out    = le_reg;
    assign rc_out    = rc_reg;

endmodule

[rtl/sorted_multiset_bound_queries_unit.sv]
// Top level of the sorted multiset bound query unit: fill count, cell chain
// and response register. Depends on smbq_pkg and smbq_cell.
//
// The unit accepts one request per cycle unless its output is stalled. Every
// request walks the chain of DEPTH cells one cell per cycle, inserting its
// value on the way and collecting bounds, counts and the ranked element; a
// stalled output holds the whole chain. Later requests see every earlier
// load and clear. The missing value is applied at the response register.
module sorted_multiset_bound_queries_unit #(
    parameter int DEPTH = smbq_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           in_valid,
    output logic           in_ready,
    input  smbq_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output smbq_pkg::rsp_t out_data
);
    import smbq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic signed [31:0] missing_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    rsp_t               out_data_reg;
    rsp_t               out_data_next;
    logic               advance;
    logic               accept;
    logic               is_load;
    logic               is_full;
    tok_t               tok_head;

    logic          valid_c [0:DEPTH];
    tok_t          tok_c   [0:DEPTH];
    logic [CW-1:0] n_c     [0:DEPTH];
    logic [CW-1:0] lo_c    [0:DEPTH];
    logic [CW-1:0] le_c    [0:DEPTH];
    logic [CW-1:0] rc_c    [0:DEPTH];

    logic [CW-1:0] n_f;
    logic [CW-1:0] lo_f;
    logic [CW-1:0] le_f;
    logic [CW-1:0] rng_f;
    tok_t          tok_f;

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept = in_valid && advance;
    assign is_load = in_data.kind == KIND_LOAD;
    assign is_full = count_reg == FULL;

    always_comb
    begin
        count_next = count_reg;
        if (is_load && !is_full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (in_data.kind == KIND_CLEAR)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        tok_head            = '0;
        tok_head.insert     = is_load && !is_full;
        tok_head.dropped    = is_load && is_full;
        tok_head.key        = in_data.key_value;
        tok_head.upk        = in_data.upper_key;
        tok_head.pos        = in_data.position;
        tok_head.carry      = in_data.key_value;
    end

    assign tok_c[0]   = tok_head;
    assign valid_c[0] = in_valid;
    assign n_c[0]     = count_next;
    assign lo_c[0]    = '0;
    assign le_c[0]    = '0;
    assign rc_c[0]    = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        smbq_cell #(
            .DEPTH(DEPTH),
            .IDX  (i),
            .CW   (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .valid_in (valid_c[i]),
            .tok_in   (tok_c[i]),
            .n_in     (n_c[i]),
            .lo_in    (lo_c[i]),
            .le_in    (le_c[i]),
            .rc_in    (rc_c[i]),
            .valid_out(valid_c[i+1]),
            .tok_out  (tok_c[i+1]),
            .n_out    (n_c[i+1]),
            .lo_out   (lo_c[i+1]),
            .le_out   (le_c[i+1]),
            .rc_out   (rc_c[i+1])
        );
    end

    always_comb
    begin
        tok_f = tok_c[DEPTH];
        n_f   = n_c[DEPTH];
        lo_f  = lo_c[DEPTH];
        le_f  = le_c[DEPTH];
        rng_f = (tok_f.upk < tok_f.key) ? '0 : (rc_c[DEPTH] - lo_f);

        out_data_next.at_least         = tok_f.ge_found ? tok_f.ge_val : missing_reg;
        out_data_next.above            = tok_f.gt_found ? tok_f.gt_val : missing_reg;
        out_data_next.at_most          = (le_f != '0) ? tok_f.le_val : missing_reg;
        out_data_next.below            = (lo_f != '0) ? tok_f.lt_val : missing_reg;
        out_data_next.less_count       = 7'(lo_f);
        out_data_next.less_equal_count = 7'(le_f);
        out_data_next.equal_count      = 7'(le_f - lo_f);
        out_data_next.range_count      = 7'(rng_f);
        out_data_next.present          = le_f != lo_f;
        out_data_next.ranked_element   = tok_f.rank_found ? tok_f.rank_val : missing_reg;
        out_data_next.size             = 7'(n_f);
        out_data_next.dropped          = tok_f.dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missing_reg   <= MISSING_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                missing_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (advance)
            begin
                out_valid_reg <= valid_c[DEPTH];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_c[DEPTH])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count beyond depth");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.kind == KIND_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    a_full_load_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_load && is_full) |=> (count_reg == FULL))
        else $error("dropped load changed the fill count");

endmodule

[tb/sv/smbq_checker.sv]
// Response checker for the sorted multiset bound query unit: tracks the missing
// value from cfg writes and the table from accepted requests, and compares
// each response. Depends on smbq_pkg; sits beside the unit in the testbench top.
module smbq_checker #(
    parameter int DEPTH = smbq_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           in_valid,
    input  logic           in_ready,
    input  smbq_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  smbq_pkg::rsp_t out_data,
    output int             failures,
    output int             pending,
    output int             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import smbq_pkg::*;

    logic signed [31:0] sorted_vals [DEPTH];
    int                 fill;
    logic signed [31:0] missing;
    rsp_t               rsp_queue [$];
    int                 fail_count;
    int                 checked_count;

    function automatic int count_lt(input logic signed [31:0] v);
        int c;
        int i;
        c = 0;
        for (i = 0; i < fill; i++)
            if (sorted_vals[i] < v)
                c++;
        return c;
    endfunction

    function automatic int count_le(input logic signed [31:0] v);
        int c;
        int i;
        c = 0;
        for (i = 0; i < fill; i++)
            if (sorted_vals[i] <= v)
                c++;
        return c;
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t               p;
        logic signed [31:0] key;
        logic signed [31:0] upk;
        int                 lo;
        int                 le;
        int                 ins;
        int                 rng;
        int                 i;
        logic               drop;
        key  = r.key_value;
        upk  = r.upper_key;
        drop = 1'b0;
        if (r.kind == KIND_LOAD)
        begin
            if (fill >= DEPTH)
            begin
                drop = 1'b1;
            end
            else
            begin
                ins = count_le(key);
                for (i = fill; i > ins; i--)
                    sorted_vals[i] = sorted_vals[i - 1];
                sorted_vals[ins] = key;
                fill++;
            end
        end
        else if (r.kind == KIND_CLEAR)
        begin
            fill = 0;
        end
        lo = count_lt(key);
        le = count_le(key);
        if (upk < key)
            rng = 0;
        else
            rng = count_lt(upk) - lo;
        p.at_least         = (lo < fill) ? sorted_vals[lo] : missing;
        p.above            = (le < fill) ? sorted_vals[le] : missing;
        p.at_most          = (le > 0) ? sorted_vals[le - 1] : missing;
        p.below            = (lo > 0) ? sorted_vals[lo - 1] : missing;
        p.less_count       = 7'(lo);
        p.less_equal_count = 7'(le);
        p.equal_count      = 7'(le - lo);
        p.range_count      = 7'(rng);
        p.present          = (le > lo);
        p.ranked_element   = (int'(r.position) < fill) ? sorted_vals[r.position] : missing;
        p.size             = 7'(fill);
        p.dropped          = drop;
        return p;
    endfunction

    task automatic show_field(input string name, input logic [31:0] w, input logic [31:0] g);
        if (w !== g)
            $display("    %s: expected %0d (0x%08h) got %0d (0x%08h)",
                     name, $signed(w), w, $signed(g), g);
    endtask

    task automatic compare_rsp(input rsp_t want, input rsp_t got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("[%0t] response %0d differs", $realtime, checked_count);
                show_field("at_least", want.at_least, got.at_least);
                show_field("above", want.above, got.above);
                show_field("at_most", want.at_most, got.at_most);
                show_field("below", want.below, got.below);
                show_field("less_count", 32'(want.less_count), 32'(got.less_count));
                show_field("less_equal_count", 32'(want.less_equal_count),
                           32'(got.less_equal_count));
                show_field("equal_count", 32'(want.equal_count), 32'(got.equal_count));
                show_field("range_count", 32'(want.range_count), 32'(got.range_count));
                show_field("present", 32'(want.present), 32'(got.present));
                show_field("ranked_element", want.ranked_element, got.ranked_element);
                show_field("size", 32'(want.size), 32'(got.size));
                show_field("dropped", 32'(want.dropped), 32'(got.dropped));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            fill          = 0;
            missing       = MISSING_RESET;
            fail_count    = 0;
            checked_count = 0;
            rsp_queue.delete();
            failures <= 0;
            pending  <= 0;
            checked  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] response with no request outstanding: 0x%h",
                                 $realtime, out_data);
                end
                else
                begin
                    want = rsp_queue.pop_front();
                    compare_rsp(want, out_data);
                end
                checked_count++;
            end
            if (cfg_we)
                missing = cfg_wdata;
            if (in_valid && in_ready)
                rsp_queue.push_back(apply_request(in_data));
            failures <= fail_count;
            pending  <= rsp_queue.size();
            checked  <= checked_count;
        end
    end

endmodule

[tb/sv/testbench.sv]
// Testbench top for sorted_multiset_bound_queries_unit: clock, reset, request
// stimulus under several pacing modes and missing-value settings, and verdict.
// Depends on smbq_pkg, the unit itself and smbq_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smbq_pkg::*;

    localparam int                 DEPTH        = DEPTH_DEFAULT;
    localparam logic [1:0]         KIND_SPARE   = 2'd3;
    localparam logic signed [31:0] INT_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX      = 32'sh7fff_ffff;
    localparam int                 RANDOM_ITEMS = 1750;
    localparam int                 PHASES       = 12;
    localparam int                 LIMIT        = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    req_t        in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rsp_t        out_data;

    int failures;
    int pending;
    int checked;

    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 sent      = 0;
    int                 settings  = 0;
    int                 cycles    = 0;
    logic signed [31:0] center    = '0;

    always #5 clk = ~clk;

    sorted_multiset_bound_queries_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    smbq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles with %0d responses outstanding",
                     cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(input logic [1:0] kind, input logic signed [31:0] key,
                        input logic signed [31:0] upk, input logic [5:0] pos);
        req_t r;
        int   gaps;
        r.kind      = kind;
        r.key_value = key;
        r.upper_key = upk;
        r.position  = pos;
        gaps = 0;
        while (gaps < 20 && $urandom_range(99) < idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(5))
                    0:       v = INT_MIN;
                    1:       v = INT_MIN + 1;
                    2:       v = INT_MAX;
                    3:       v = INT_MAX - 1;
                    4:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(12)) - 6;
            4, 5, 6: v = center + int'($urandom_range(15));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pick_upper(input logic signed [31:0] key);
        logic signed [31:0] v;
        case ($urandom_range(3))
            0:       v = key;
            1:       v = key + int'($urandom_range(24)) - 4;
            2:       v = pick_value();
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_request(input logic [1:0] kind);
        logic signed [31:0] k;
        logic [5:0]         pos;
        k   = pick_value();
        pos = ($urandom_range(1) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(16));
        send(kind, k, pick_upper(k), pos);
    endtask

    task automatic run_sequence();
        int sel;
        int n;
        int i;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            n = ($urandom_range(2) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
            random_request(KIND_CLEAR);
            for (i = 0; i < n; i++)
            begin
                random_request(KIND_LOAD);
                if ($urandom_range(9) < 4)
                    random_request(KIND_QUERY);
            end
        end
        else if (sel < 8)
        begin
            n = $urandom_range(5, 20);
            for (i = 0; i < n; i++)
                random_request(KIND_QUERY);
        end
        else
        begin
            n = $urandom_range(5, 15);
            for (i = 0; i < n; i++)
                random_request(2'($urandom_range(3)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_missing(input logic signed [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int                 p;
        int                 target;
        logic signed [31:0] mv;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(KIND_QUERY, 0, 10, 0);
        send(KIND_LOAD, INT_MIN, 0, 0);
        send(KIND_LOAD, INT_MAX, 0, 63);
        send(KIND_LOAD, 0, 0, 1);
        send(KIND_LOAD, 0, 1, 2);
        send(KIND_LOAD, 5, INT_MAX, 3);
        send(KIND_QUERY, 0, 5, 0);
        send(KIND_QUERY, 0, 0, 1);
        send(KIND_QUERY, 5, 0, 2);
        send(KIND_QUERY, INT_MIN, INT_MAX, 4);
        send(KIND_QUERY, INT_MAX, INT_MIN, 5);
        send(KIND_QUERY, 3, 6, 63);
        send(KIND_SPARE, -1, 5, 2);
        send(KIND_LOAD, -1, INT_MAX, 63);
        send(KIND_QUERY, INT_MIN + 1, INT_MAX, 1);
        send(KIND_QUERY, INT_MAX - 1, INT_MAX, 5);
        send(KIND_CLEAR, 0, INT_MAX, 0);
        send(KIND_QUERY, INT_MAX, INT_MAX, 0);
        send(KIND_LOAD, INT_MAX, INT_MIN, 0);
        send(KIND_QUERY, INT_MAX, INT_MAX, 0);
        send(KIND_QUERY, INT_MIN, INT_MAX, 1);
        send(KIND_CLEAR, INT_MIN, INT_MIN, 63);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       mv = 0;
                1:       mv = INT_MIN;
                2:       mv = INT_MAX;
                3:       mv = MISSING_RESET;
                default: mv = $urandom;
            endcase
            write_missing(mv);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 71;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 71;
                end
                default:
                begin
                    idle_pct = 16;
                    stall_pct <= 16;
                end
            endcase
            center = ($urandom_range(1) == 0) ? $urandom : int'($urandom_range(40)) - 20;
            target = sent + RANDOM_ITEMS / PHASES;
            while (sent < target)
                run_sequence();
            drain();
        end

        $display("Sent %0d requests and checked %0d responses under %0d missing-value writes,",
                 sent, checked, settings);
        $display("with fills past capacity, clears, duplicate keys and four pacing modes.");
        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
